>>> rtl/core/fractal_perlin_noise_2d_core_macros.svh
// ----------------------------------------------------------------------------
// fractal perlin noise core assertion macros
// concurrent checks on clk, disabled while rst_n is low; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef FRACTAL_PERLIN_NOISE_2D_CORE_MACROS_SVH
`define FRACTAL_PERLIN_NOISE_2D_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FPN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpn same-cycle check failed");
// next-cycle implication
`define FPN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpn next-cycle check failed");
`else
`define FPN_ASSERT_IMP(lbl, ante, cons)
`define FPN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/fpn_pkg.sv
// ----------------------------------------------------------------------------
// fpn_pkg
// shared widths, types and constants of the fractal perlin noise core
// ----------------------------------------------------------------------------
`default_nettype none
package fpn_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int MAX_OCTAVES = 16;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int OCT_W   = $clog2(MAX_OCTAVES);
    localparam int COORD_W = FRAC_BITS + IDX_W;

    // lattice values, gradients and lerp results (signed q.16)
    localparam int VAL_W  = 20;
    // shared multiplier operands and product
    localparam int MUL_W  = 22;
    localparam int PROD_W = 2 * MUL_W;

    localparam int AMP_W   = 17;
    localparam int SUM_W   = 21;
    localparam int TOTAL_W = 24;

    // normalizing divide: |total| * 2^15 over the amplitude sum
    localparam int NUM_W = TOTAL_W - 1 + 15;
    localparam int DEN_W = SUM_W;
    localparam int CNT_W = $clog2(NUM_W);

    // gradient hash decode
    localparam logic [3:0] HASH_X_LIM = 4'd8;
    localparam logic [3:0] HASH_Y_LIM = 4'd4;
    localparam logic [3:0] HASH_ALT_A = 4'd12;
    localparam logic [3:0] HASH_ALT_B = 4'd14;

    // register indexes
    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_PERSISTENCE  = 1'b1;

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/fpn_divider.sv
// ----------------------------------------------------------------------------
// fpn_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module fpn_divider
    import fpn_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output div_stat_t             stat,
    output logic      [NUM_W-1:0] quo
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule
`default_nettype wire

>>> rtl/core/fractal_perlin_noise_2d_core.sv
// ----------------------------------------------------------------------------
// fractal_perlin_noise_2d_core
// improved perlin gradient noise summed over octaves at a 2d point
// ----------------------------------------------------------------------------
// A mode-0 word writes one entry of the 256-entry permutation table; all
// entries must be written before the first evaluation. A mode-1 word
// evaluates fbm noise at (coord_x, coord_y) in signed q16.16 and returns one
// q1.15 word, saturated to +/-1. Per octave, an evaluation runs one setup
// state, 11 table reads through the single memory read port, and fade, lerp
// and amplitude products on one shared 22x22 multiplier; the final
// normalization runs through a one-bit-per-cycle divider of 38 steps, after
// which the quotient is taken and the word presented when the output is free.
// in_ready is high only while the sequencer is idle. No clearing pass is run
// after reset.
`default_nettype none
`include "fractal_perlin_noise_2d_core_macros.svh"
module fractal_perlin_noise_2d_core
    import fpn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                cfg_write_en,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    // input words
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                mode,
    input  wire logic [7:0]          table_index,
    input  wire logic [7:0]          table_value,
    input  wire logic signed [31:0]  coord_x,
    input  wire logic signed [31:0]  coord_y,
    // result words
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [15:0]       noise_value
);

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_OCT  = 5'd1;
    localparam logic [4:0] S_READ = 5'd2;
    localparam logic [4:0] S_F0   = 5'd3;
    localparam logic [4:0] S_F1   = 5'd4;
    localparam logic [4:0] S_F2   = 5'd5;
    localparam logic [4:0] S_F3   = 5'd6;
    localparam logic [4:0] S_L0   = 5'd7;
    localparam logic [4:0] S_L1   = 5'd8;
    localparam logic [4:0] S_L2   = 5'd9;
    localparam logic [4:0] S_L3   = 5'd10;
    localparam logic [4:0] S_L4   = 5'd11;
    localparam logic [4:0] S_L5   = 5'd12;
    localparam logic [4:0] S_L6   = 5'd13;
    localparam logic [4:0] S_L7   = 5'd14;
    localparam logic [4:0] S_DIVW = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    localparam logic [3:0] RD_LAST = 4'd10;
    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
    localparam val_t VAL_ONE = VAL_W'(65536);

    function automatic val_t grad2(input logic [3:0] h, input val_t x, input val_t y);
        val_t u;
        val_t v;
        val_t su;
        val_t sv;
        u = (h < HASH_X_LIM) ? x : y;
        if (h < HASH_Y_LIM)
            v = y;
        else if (h == HASH_ALT_A || h == HASH_ALT_B)
            v = x;
        else
            v = '0;
        su = h[0] ? -u : u;
        sv = h[1] ? -v : v;
        return su + sv;
    endfunction

    // configuration registers
    logic [4:0]  octave_count_reg;
    logic [15:0] persistence_reg;

    // sequencer and datapath registers
    logic [4:0]          state_reg, state_next;
    logic [COORD_W-1:0]  cx_reg, cx_next;
    logic [COORD_W-1:0]  cy_reg, cy_next;
    logic [OCT_W-1:0]    oct_reg, oct_next;
    logic [OCT_W-1:0]    oct_last_reg, oct_last_next;
    logic [7:0]          iy_reg, iy_next;
    logic [15:0]         fx_reg, fx_next;
    logic [15:0]         fy_reg, fy_next;
    logic [7:0]          ix_reg, ix_next;
    logic [7:0]          a_reg, a_next;
    logic [7:0]          b_reg, b_next;
    logic [7:0]          aa_reg, aa_next;
    logic [7:0]          ab_reg, ab_next;
    logic [7:0]          ba_reg, ba_next;
    logic [7:0]          bb_reg, bb_next;
    logic [3:0]          h_aa_reg, h_aa_next;
    logic [3:0]          h_ab_reg, h_ab_next;
    logic [3:0]          h_ba_reg, h_ba_next;
    logic [3:0]          h_bb_reg, h_bb_next;
    logic [3:0]          rd_cnt_reg, rd_cnt_next;
    logic                fsel_reg, fsel_next;
    logic [31:0]         tt_reg, tt_next;
    logic [15:0]         u_reg, u_next;
    logic [15:0]         v_reg, v_next;
    val_t                lo_reg, lo_next;
    val_t                hi_reg, hi_next;
    val_t                nz_reg, nz_next;
    logic [AMP_W-1:0]    amp_reg, amp_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         noise_reg, noise_next;

    // shared multiplier operands
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;

    // permutation table
    logic [7:0] perm_mem [TABLE_SIZE];
    logic [7:0] rdata_reg;
    logic [7:0] rd_addr;
    logic       tbl_we;

    // divider
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_quo;
    div_stat_t        div_stat;

    // misc combinational
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [15:0]        t_cur;
    logic [36:0]        tt37;
    logic [36:0]        t37;
    logic [36:0]        poly_full;
    logic [20:0]        poly;
    logic [27:0]        f_raw;
    logic [15:0]        f_cap;
    val_t               fxs, fys, x1, y1;
    val_t               g_aa, g_ba, g_ab, g_bb;
    logic [TOTAL_W-1:0] total_abs;
    logic               in_acc;
    logic               out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign tbl_we    = in_acc && (mode == MODE_WRITE);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= 5'd4;
            persistence_reg  <= 16'd32768;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[4:0];
                REG_PERSISTENCE:  persistence_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // scaled coordinate: only the low cell bits and the fraction matter
    assign sx = cx_reg << oct_reg;
    assign sy = cy_reg << oct_reg;

    // fade polynomial 6t^2 - 15t + 10 in q.16, from the registered t*t
    assign t_cur     = fsel_reg ? fy_reg : fx_reg;
    assign tt37      = {5'b0, tt_reg};
    assign t37       = {21'b0, t_cur};
    assign poly_full = (tt37 << 2) + (tt37 << 1) + (37'd10 << 32)
                       - (t37 << 20) + (t37 << 16);
    assign poly      = poly_full[36:16];
    assign f_raw     = prod_reg[43:16];
    assign f_cap     = (|f_raw[27:16]) ? 16'hFFFF : f_raw[15:0];

    // corner offsets and gradients
    assign fxs  = {4'b0, fx_reg};
    assign fys  = {4'b0, fy_reg};
    assign x1   = fxs - VAL_ONE;
    assign y1   = fys - VAL_ONE;
    assign g_aa = grad2(h_aa_reg, fxs, fys);
    assign g_ba = grad2(h_ba_reg, x1, fys);
    assign g_ab = grad2(h_ab_reg, fxs, y1);
    assign g_bb = grad2(h_bb_reg, x1, y1);

    assign total_abs = total_reg[TOTAL_W-1] ? -total_reg : total_reg;
    assign div_num   = {total_abs[TOTAL_W-2:0], 15'b0};

    // table read address by read step
    always_comb
    begin
        case (rd_cnt_reg)
            4'd0:    rd_addr = ix_reg;
            4'd1:    rd_addr = ix_reg + 8'd1;
            4'd2:    rd_addr = a_reg;
            4'd3:    rd_addr = a_reg + 8'd1;
            4'd4:    rd_addr = b_reg;
            4'd5:    rd_addr = b_reg + 8'd1;
            4'd6:    rd_addr = aa_reg;
            4'd7:    rd_addr = ba_reg;
            4'd8:    rd_addr = ab_reg;
            4'd9:    rd_addr = bb_reg;
            default: rd_addr = bb_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            perm_mem[table_index] <= table_value;
        rdata_reg <= perm_mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        oct_next      = oct_reg;
        oct_last_next = oct_last_reg;
        ix_next       = ix_reg;
        iy_next       = iy_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        aa_next       = aa_reg;
        ab_next       = ab_reg;
        ba_next       = ba_reg;
        bb_next       = bb_reg;
        h_aa_next     = h_aa_reg;
        h_ab_next     = h_ab_reg;
        h_ba_next     = h_ba_reg;
        h_bb_next     = h_bb_reg;
        rd_cnt_next   = rd_cnt_reg;
        fsel_next     = fsel_reg;
        tt_next       = tt_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        nz_next       = nz_reg;
        amp_next      = amp_reg;
        sum_next      = sum_reg;
        total_next    = total_reg;
        quo_next      = quo_reg;
        out_valid_next = out_valid_reg && !out_ready;
        noise_next    = noise_reg;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && mode == MODE_EVAL)
                begin
                    cx_next    = coord_x[COORD_W-1:0];
                    cy_next    = coord_y[COORD_W-1:0];
                    oct_next   = '0;
                    if (octave_count_reg == 5'd0)
                        oct_last_next = '0;
                    else if (octave_count_reg > 5'(MAX_OCTAVES))
                        oct_last_next = OCT_W'(MAX_OCTAVES - 1);
                    else
                        oct_last_next = OCT_W'(octave_count_reg - 5'd1);
                    amp_next   = AMP_ONE;
                    sum_next   = '0;
                    total_next = '0;
                    fsel_next  = 1'b0;
                    state_next = S_OCT;
                end
            end
            S_OCT:
            begin
                ix_next     = sx[COORD_W-1:FRAC_BITS];
                iy_next     = sy[COORD_W-1:FRAC_BITS];
                fx_next     = sx[FRAC_BITS-1:0];
                fy_next     = sy[FRAC_BITS-1:0];
                rd_cnt_next = '0;
                state_next  = S_READ;
            end
            S_READ:
            begin
                // data of the previous read step arrives now
                case (rd_cnt_reg)
                    4'd1:    a_next    = rdata_reg + iy_reg;
                    4'd2:    b_next    = rdata_reg + iy_reg;
                    4'd3:    aa_next   = rdata_reg;
                    4'd4:    ab_next   = rdata_reg;
                    4'd5:    ba_next   = rdata_reg;
                    4'd6:    bb_next   = rdata_reg;
                    4'd7:    h_aa_next = rdata_reg[3:0];
                    4'd8:    h_ba_next = rdata_reg[3:0];
                    4'd9:    h_ab_next = rdata_reg[3:0];
                    4'd10:   h_bb_next = rdata_reg[3:0];
                    default: ;
                endcase
                rd_cnt_next = rd_cnt_reg + 4'd1;
                if (rd_cnt_reg == RD_LAST)
                    state_next = S_F0;
            end
            S_F0:
            begin
                mul_a      = {6'b0, t_cur};
                mul_b      = {6'b0, t_cur};
                state_next = S_F1;
            end
            S_F1:
            begin
                tt_next    = prod_reg[31:0];
                mul_a      = {6'b0, prod_reg[31:16]};
                mul_b      = {6'b0, t_cur};
                state_next = S_F2;
            end
            S_F2:
            begin
                mul_a      = {6'b0, prod_reg[31:16]};
                mul_b      = {1'b0, poly};
                state_next = S_F3;
            end
            S_F3:
            begin
                if (!fsel_reg)
                begin
                    u_next     = f_cap;
                    fsel_next  = 1'b1;
                    state_next = S_F0;
                end
                else
                begin
                    v_next     = f_cap;
                    fsel_next  = 1'b0;
                    state_next = S_L0;
                end
            end
            S_L0:
            begin
                mul_a      = MUL_W'(g_ba) - MUL_W'(g_aa);
                mul_b      = {6'b0, u_reg};
                state_next = S_L1;
            end
            S_L1:
            begin
                lo_next    = g_aa + prod_reg[VAL_W+15:16];
                mul_a      = MUL_W'(g_bb) - MUL_W'(g_ab);
                mul_b      = {6'b0, u_reg};
                state_next = S_L2;
            end
            S_L2:
            begin
                hi_next    = g_ab + prod_reg[VAL_W+15:16];
                state_next = S_L3;
            end
            S_L3:
            begin
                mul_a      = MUL_W'(hi_reg) - MUL_W'(lo_reg);
                mul_b      = {6'b0, v_reg};
                state_next = S_L4;
            end
            S_L4:
            begin
                nz_next    = lo_reg + prod_reg[VAL_W+15:16];
                state_next = S_L5;
            end
            S_L5:
            begin
                mul_a      = MUL_W'(nz_reg);
                mul_b      = {{(MUL_W-AMP_W){1'b0}}, amp_reg};
                state_next = S_L6;
            end
            S_L6:
            begin
                total_next = total_reg + prod_reg[TOTAL_W+15:16];
                sum_next   = sum_reg + SUM_W'(amp_reg);
                mul_a      = {{(MUL_W-AMP_W){1'b0}}, amp_reg};
                mul_b      = {6'b0, persistence_reg};
                state_next = S_L7;
            end
            S_L7:
            begin
                amp_next = prod_reg[AMP_W+15:16];
                if (oct_reg == oct_last_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
                else
                begin
                    oct_next   = oct_reg + 1'b1;
                    state_next = S_OCT;
                end
            end
            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    quo_next   = div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    // saturate to q1.15, sign from the weighted total
                    if (!total_reg[TOTAL_W-1])
                        noise_next = (quo_reg > NUM_W'(32767)) ? 16'h7FFF : quo_reg[15:0];
                    else
                        noise_next = (quo_reg > NUM_W'(32768)) ? 16'h8000 : -quo_reg[15:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oct_reg       <= '0;
            oct_last_reg  <= '0;
            rd_cnt_reg    <= '0;
            fsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oct_reg       <= oct_next;
            oct_last_reg  <= oct_last_next;
            rd_cnt_reg    <= rd_cnt_next;
            fsel_reg      <= fsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ix_reg    <= ix_next;
        iy_reg    <= iy_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        aa_reg    <= aa_next;
        ab_reg    <= ab_next;
        ba_reg    <= ba_next;
        bb_reg    <= bb_next;
        h_aa_reg  <= h_aa_next;
        h_ab_reg  <= h_ab_next;
        h_ba_reg  <= h_ba_next;
        h_bb_reg  <= h_bb_next;
        tt_reg    <= tt_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        nz_reg    <= nz_next;
        amp_reg   <= amp_next;
        sum_reg   <= sum_next;
        total_reg <= total_next;
        quo_reg   <= quo_next;
        prod_reg  <= prod_next;
        noise_reg <= noise_next;
    end

    fpn_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sum_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

    // octave counter stays within the clamped count while busy
    `FPN_ASSERT_IMP(a_oct_bound, state_reg != S_IDLE, oct_reg <= oct_last_reg)
    // divider only runs while the sequencer waits for it
    `FPN_ASSERT_IMP(a_div_owned, div_stat.busy, state_reg == S_DIVW)
    // normalization never divides by zero
    `FPN_ASSERT_IMP(a_sum_nonzero, state_reg == S_DIVW, sum_reg != '0)
    // a finished evaluation always presents its word
    `FPN_ASSERT_NXT(a_push_valid, state_reg == S_DONE && out_free, out_valid_reg)

endmodule
`default_nettype wire
